// ===== design/sfcd_pkg.sv =====
`default_nettype none

package sfcd_pkg;

    // Frame geometry.
    localparam int NUM_CHANNELS = 16;
    localparam int FRAME_BYTES  = 25;
    localparam int DATA_BYTES   = 22;
    localparam int CHAN_BITS    = 11;
    localparam int FRAME_W      = DATA_BYTES * 8;
    localparam int BITPOS_W     = $clog2(FRAME_W);

    // Marker bytes at both ends of a frame.
    localparam logic [7:0] HEADER_BYTE = 8'h0F;
    localparam logic [7:0] FOOTER_BYTE = 8'h00;

    // Field widths.
    localparam int IDX_W   = 4;
    localparam int RAW_W   = 11;
    localparam int CAL_W   = 12;
    localparam int SCALE_W = 16;
    localparam int BIAS_W  = 26;
    localparam int PROD_W  = RAW_W + SCALE_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int FRAC_W  = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = BIAS_W;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_IDX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_IDX  = 2'd1;

    // Calibration defaults: gain about 0.625748, offset about 875.23353.
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd41009;
    localparam logic [BIAS_W-1:0]  BIAS_RESET  = 26'd57359305;

    // Number of whole frames held between front and back.
    localparam int QUEUE_DEPTH = 2;

    // The 22 data bytes of one frame, byte k at bits 8k+7 to 8k.
    typedef logic [FRAME_W-1:0] t_frame;

    // A frame request from the front to the queue.
    typedef struct packed {
        logic   valid;
        t_frame data;
    } t_frame_push;

    // Queue fill status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

// ===== design/sfcd_front.sv =====
`default_nettype none

module sfcd_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [7:0]           i_byte,
    input  wire sfcd_pkg::t_queue_status i_status,
    output logic                      o_stall,
    output sfcd_pkg::t_frame_push     o_push
);

    logic [7:0] r_win [sfcd_pkg::FRAME_BYTES];
    logic       w_accept;
    logic       w_match;

    // A byte is taken whenever the queue has room for a possible frame.
    assign o_stall  = i_status.full;
    assign w_accept = i_valid && !i_status.full;

    // After the shift the oldest byte is the current second one.
    assign w_match = (r_win[1] == sfcd_pkg::HEADER_BYTE) && (i_byte == sfcd_pkg::FOOTER_BYTE);

    // Data bytes of the shifted window are the current bytes 2 to 23.
    always_comb begin
        o_push.valid = w_accept && w_match;
        for (int k = 0; k < sfcd_pkg::DATA_BYTES; k++) begin
            o_push.data[8*k +: 8] = r_win[k+2];
        end
    end

    // Sliding window of the most recent bytes, oldest at entry 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < sfcd_pkg::FRAME_BYTES; k++) begin
                r_win[k] <= 8'h00;
            end
        end else if (w_accept) begin
            for (int k = 0; k < sfcd_pkg::FRAME_BYTES - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[sfcd_pkg::FRAME_BYTES-1] <= i_byte;
        end
    end

endmodule

`default_nettype wire

// ===== design/sfcd_queue.sv =====
`default_nettype none

module sfcd_queue #(
    parameter int DEPTH = sfcd_pkg::QUEUE_DEPTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire sfcd_pkg::t_frame_push   i_push,
    input  wire logic                    i_pop,
    output sfcd_pkg::t_frame             o_head,
    output sfcd_pkg::t_queue_status      o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfcd_pkg::t_frame   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    assign w_push = i_push.valid && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;

    // Frame storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/sfcd_back.sv =====
`default_nettype none

module sfcd_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire sfcd_pkg::t_frame                i_head,
    input  wire sfcd_pkg::t_queue_status         i_status,
    input  wire logic [sfcd_pkg::SCALE_W-1:0]    i_scale,
    input  wire logic [sfcd_pkg::BIAS_W-1:0]     i_bias,
    input  wire logic                            i_stall,
    output logic                                 o_pop,
    output logic                                 o_valid,
    output logic [sfcd_pkg::IDX_W-1:0]           o_channel_index,
    output logic [sfcd_pkg::RAW_W-1:0]           o_raw_value,
    output logic [sfcd_pkg::CAL_W-1:0]           o_calibrated_value,
    output logic                                 o_last_channel
);

    localparam logic [sfcd_pkg::IDX_W-1:0] LAST_CH = sfcd_pkg::IDX_W'(sfcd_pkg::NUM_CHANNELS - 1);

    logic [sfcd_pkg::IDX_W-1:0]    r_ch;
    logic                          w_en;
    logic                          w_issue;
    logic [sfcd_pkg::BITPOS_W-1:0] w_bitpos;
    logic [sfcd_pkg::RAW_W-1:0]    w_raw;
    logic [sfcd_pkg::SUM_W-1:0]    w_sum;

    logic                          r_s1_valid;
    logic [sfcd_pkg::IDX_W-1:0]    r_s1_idx;
    logic [sfcd_pkg::RAW_W-1:0]    r_s1_raw;
    logic [sfcd_pkg::PROD_W-1:0]   r_s1_prod;
    logic                          r_s1_last;

    logic                          r_out_valid;
    logic [sfcd_pkg::IDX_W-1:0]    r_out_idx;
    logic [sfcd_pkg::RAW_W-1:0]    r_out_raw;
    logic [sfcd_pkg::CAL_W-1:0]    r_out_cal;
    logic                          r_out_last;

    // The whole pipeline moves when the output register is free or being taken.
    assign w_en    = !r_out_valid || !i_stall;
    assign w_issue = w_en && !i_status.empty;
    assign o_pop   = w_issue && (r_ch == LAST_CH);

    // Channel c starts at bit 11c of the data bytes.
    assign w_bitpos = sfcd_pkg::BITPOS_W'(r_ch) * sfcd_pkg::BITPOS_W'(sfcd_pkg::CHAN_BITS);
    assign w_raw    = i_head[w_bitpos +: sfcd_pkg::RAW_W];

    // Channel counter walks the head frame once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch <= '0;
        end else if (w_issue) begin
            r_ch <= r_ch + 1'b1;
        end
    end

    // First stage: unpack and multiply by the gain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_idx  <= r_ch;
            r_s1_raw  <= w_raw;
            r_s1_prod <= sfcd_pkg::PROD_W'(w_raw) * sfcd_pkg::PROD_W'(i_scale);
            r_s1_last <= (r_ch == LAST_CH);
        end
    end

    // Second stage: add the offset and drop the fraction.
    assign w_sum = sfcd_pkg::SUM_W'(r_s1_prod) + sfcd_pkg::SUM_W'(i_bias);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_s1_valid) begin
            r_out_idx  <= r_s1_idx;
            r_out_raw  <= r_s1_raw;
            r_out_cal  <= w_sum[sfcd_pkg::FRAC_W +: sfcd_pkg::CAL_W];
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_channel_index    = r_out_idx;
    assign o_raw_value        = r_out_raw;
    assign o_calibrated_value = r_out_cal;
    assign o_last_channel     = r_out_last;

endmodule

`default_nettype wire

// ===== design/sbus_frame_channel_decoder.sv =====
// Channel 0 of a frame goes from the frame queue through the first stage to the output
// register once the closing byte is taken, then one channel per cycle while the output
// is not stalled (16 per frame). Throughput: one byte per cycle; the input stalls only
// while the frame queue is full, which happens when frames close faster than the back
// end unpacks them, or when result stalls hold the back end while another frame waits.
// Reset clears the byte window to zeros, empties the frame queue and the output,
// and loads the default gain and offset.
`default_nettype none

module sbus_frame_channel_decoder #(
    parameter int QUEUE_DEPTH = sfcd_pkg::QUEUE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_rx_valid,
    output logic                                   o_rx_stall,
    input  wire logic [7:0]                        i_rx_byte,
    output logic                                   o_res_valid,
    input  wire logic                              i_res_stall,
    output logic [sfcd_pkg::IDX_W-1:0]             o_channel_index,
    output logic [sfcd_pkg::RAW_W-1:0]             o_raw_value,
    output logic [sfcd_pkg::CAL_W-1:0]             o_calibrated_value,
    output logic                                   o_last_channel,
    input  wire logic                              i_cfg_we,
    input  wire logic [sfcd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sfcd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [sfcd_pkg::SCALE_W-1:0] r_scale;
    logic [sfcd_pkg::BIAS_W-1:0]  r_bias;
    sfcd_pkg::t_frame_push        w_push;
    sfcd_pkg::t_frame             w_head;
    sfcd_pkg::t_queue_status      w_status;
    logic                         w_pop;

    // Calibration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= sfcd_pkg::SCALE_RESET;
            r_bias  <= sfcd_pkg::BIAS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfcd_pkg::CFG_SCALE_IDX: r_scale <= i_cfg_data[sfcd_pkg::SCALE_W-1:0];
                sfcd_pkg::CFG_BIAS_IDX:  r_bias  <= i_cfg_data[sfcd_pkg::BIAS_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: byte window and frame detection.
    sfcd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_rx_valid),
        .i_byte   (i_rx_byte),
        .i_status (w_status),
        .o_stall  (o_rx_stall),
        .o_push   (w_push)
    );

    // Frames waiting to be unpacked.
    sfcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    // Back end: channel unpacking and calibration.
    sfcd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (w_head),
        .i_status           (w_status),
        .i_scale            (r_scale),
        .i_bias             (r_bias),
        .i_stall            (i_res_stall),
        .o_pop              (w_pop),
        .o_valid            (o_res_valid),
        .o_channel_index    (o_channel_index),
        .o_raw_value        (o_raw_value),
        .o_calibrated_value (o_calibrated_value),
        .o_last_channel     (o_last_channel)
    );

    // A detected frame is never offered to a full queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> !w_status.full)
        else $error("frame pushed into a full queue");

    // The end-of-frame flag marks exactly the last channel.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_last_channel ==
            (o_channel_index == sfcd_pkg::IDX_W'(sfcd_pkg::NUM_CHANNELS - 1))))
        else $error("last channel flag does not match channel index");

    // The queue is only popped while it holds a frame.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_status.empty)
        else $error("pop from an empty frame queue");

    // Reset leaves no result on the output.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

// ===== sim/tb_sbus_frame_channel_decoder.sv =====
`default_nettype none

module tb_sbus_frame_channel_decoder;

    // Spare register indexes that the block must ignore.
    localparam logic [sfcd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A_IDX = 2'd2;
    localparam logic [sfcd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B_IDX = 2'd3;

    localparam int DIRECTED_ROWS = 25;
    localparam int NUM_PHASES    = 5;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;

    // Data fill patterns for generated frames.
    localparam int FILL_ZEROS = 0;
    localparam int FILL_ONES  = 1;

    typedef enum logic [1:0] {SEQ_NOISE, SEQ_BROKEN, SEQ_CHAINED, SEQ_FRAME} t_seq_kind;

    // One decoded channel as it should leave the block.
    typedef struct packed {
        logic [sfcd_pkg::IDX_W-1:0] idx;
        logic [sfcd_pkg::RAW_W-1:0] raw;
        logic [sfcd_pkg::CAL_W-1:0] cal;
        logic                       last;
    } t_chan;

    // One row of the directed byte table.
    typedef struct packed {
        logic [7:0]                 data;
        logic                       typed;
        logic [sfcd_pkg::RAW_W-1:0] raw;
        logic [sfcd_pkg::CAL_W-1:0] cal;
    } t_stim_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_rx_valid = 1'b0;
    logic                            o_rx_stall;
    logic [7:0]                      i_rx_byte = 8'h00;
    logic                            o_res_valid;
    logic                            i_res_stall = 1'b0;
    logic [sfcd_pkg::IDX_W-1:0]      o_channel_index;
    logic [sfcd_pkg::RAW_W-1:0]      o_raw_value;
    logic [sfcd_pkg::CAL_W-1:0]      o_calibrated_value;
    logic                            o_last_channel;
    logic                            i_cfg_we = 1'b0;
    logic [sfcd_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [sfcd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Local copy of the block state and calibration registers.
    logic [7:0]                   window_q [sfcd_pkg::FRAME_BYTES] = '{default: 8'h00};
    logic [sfcd_pkg::SCALE_W-1:0] gain_q = sfcd_pkg::SCALE_RESET;
    logic [sfcd_pkg::BIAS_W-1:0]  offset_q = sfcd_pkg::BIAS_RESET;
    t_chan                        pending_q [$];

    int error_count = 0;
    int quiet_cycles = 0;
    int phase_bytes = 0;
    int sender_gap_pct = 18;
    int receiver_gap_pct = 64;

    // Header, 22 data bytes of all ones, a flags byte, then the closing zero.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{8'h0F, 1'b0, '0, '0},
        '{8'hFF, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0},
        '{8'hFF, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0},
        '{8'hFF, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0},
        '{8'hFF, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0},
        '{8'hFF, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0},
        '{8'hFF, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0},
        '{8'hFF, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0},
        '{8'hFF, 1'b0, '0, '0},
        '{8'h00, 1'b0, '0, '0},
        '{8'h00, 1'b1, 11'd2047, 12'd2156}
    };

    sbus_frame_channel_decoder u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_rx_valid         (i_rx_valid),
        .o_rx_stall         (o_rx_stall),
        .i_rx_byte          (i_rx_byte),
        .o_res_valid        (o_res_valid),
        .i_res_stall        (i_res_stall),
        .o_channel_index    (o_channel_index),
        .o_raw_value        (o_raw_value),
        .o_calibrated_value (o_calibrated_value),
        .o_last_channel     (o_last_channel),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int ch,
                               input logic [31:0] got, input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("channel %0d %s is %0d, expected %0d",
                                   ch, name, got, want));
        end
    endtask

    // Fixed-point gain and offset, truncated by the final shift.
    function automatic logic [sfcd_pkg::CAL_W-1:0] calibrate(
        input logic [sfcd_pkg::RAW_W-1:0] raw);
        logic [sfcd_pkg::SUM_W-1:0] sum;
        sum = sfcd_pkg::SUM_W'(raw) * sfcd_pkg::SUM_W'(gain_q)
            + sfcd_pkg::SUM_W'(offset_q);
        return sum[sfcd_pkg::FRAC_W +: sfcd_pkg::CAL_W];
    endfunction

    // Slide one byte into the window and tell whether it now holds a frame.
    function automatic bit shift_in(input logic [7:0] b);
        int k;
        for (k = 0; k < sfcd_pkg::FRAME_BYTES - 1; k++) begin
            window_q[k] = window_q[k + 1];
        end
        window_q[sfcd_pkg::FRAME_BYTES - 1] = b;
        return (window_q[0] == sfcd_pkg::HEADER_BYTE)
            && (window_q[sfcd_pkg::FRAME_BYTES - 1] == sfcd_pkg::FOOTER_BYTE);
    endfunction

    task automatic push_channel(input int ch, input logic [sfcd_pkg::RAW_W-1:0] raw,
                                input logic [sfcd_pkg::CAL_W-1:0] cal);
        t_chan c;
        c.idx  = sfcd_pkg::IDX_W'(ch);
        c.raw  = raw;
        c.cal  = cal;
        c.last = (ch == sfcd_pkg::NUM_CHANNELS - 1);
        pending_q.push_back(c);
    endtask

    // Unpack the 22 data bytes as one LSB-first bit stream, 11 bits per channel.
    task automatic push_predicted();
        logic [sfcd_pkg::FRAME_W-1:0] data_bits;
        logic [sfcd_pkg::RAW_W-1:0]   raw;
        int                           k;
        for (k = 0; k < sfcd_pkg::DATA_BYTES; k++) begin
            data_bits[8*k +: 8] = window_q[1 + k];
        end
        for (k = 0; k < sfcd_pkg::NUM_CHANNELS; k++) begin
            raw = data_bits[sfcd_pkg::CHAN_BITS*k +: sfcd_pkg::CHAN_BITS];
            push_channel(k, raw, calibrate(raw));
        end
    endtask

    // Offer one byte request, with random gaps, and hold it until taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_gap_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic feed(input logic [7:0] b);
        send_byte(b);
        phase_bytes++;
        if (shift_in(b)) begin
            push_predicted();
        end
    endtask

    // Drop valid and wait until every predicted channel has come out.
    task automatic settle();
        i_rx_valid <= 1'b0;
        while (pending_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sfcd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sfcd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            sfcd_pkg::CFG_SCALE_IDX: begin
                gain_q = data[sfcd_pkg::SCALE_W-1:0];
            end
            sfcd_pkg::CFG_BIAS_IDX: begin
                offset_q = data;
            end
            default: begin
            end
        endcase
    endtask

    // Mostly whole frames with random, all-zero or all-ones data; the rest is noise,
    // frames with a bad closing byte, and frames whose window reuses an inner header byte.
    task automatic send_sequence();
        t_seq_kind  kind;
        int         pick;
        int         fill;
        int         link;
        int         k;
        logic [7:0] b;
        pick = $urandom_range(9);
        kind = (pick == 0) ? SEQ_NOISE : (pick == 1) ? SEQ_BROKEN :
               (pick < 4) ? SEQ_CHAINED : SEQ_FRAME;
        if (kind == SEQ_NOISE) begin
            pick = $urandom_range(6, 1);
            for (k = 0; k < pick; k++) begin
                feed(8'($urandom()));
            end
        end else begin
            fill = $urandom_range(7);
            link = (kind == SEQ_CHAINED) ? $urandom_range(sfcd_pkg::FRAME_BYTES - 2, 1) : 0;
            feed(sfcd_pkg::HEADER_BYTE);
            for (k = 1; k < sfcd_pkg::FRAME_BYTES - 1; k++) begin
                if (k == link) begin
                    b = sfcd_pkg::HEADER_BYTE;
                end else if (fill == FILL_ZEROS) begin
                    b = 8'h00;
                end else if (fill == FILL_ONES) begin
                    b = 8'hFF;
                end else begin
                    b = 8'($urandom());
                end
                feed(b);
            end
            feed((kind == SEQ_BROKEN) ? 8'($urandom_range(255, 1)) : sfcd_pkg::FOOTER_BYTE);
            // The inner header becomes the oldest byte once link more bytes arrive.
            for (k = 1; k <= link; k++) begin
                feed((k == link) ? sfcd_pkg::FOOTER_BYTE : 8'($urandom()));
            end
        end
    endtask

    // Result side: compare each taken channel, then pick the next stall.
    always @(posedge i_clk) begin : result_check
        t_chan want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (pending_q.size() == 0) begin
                report_error($sformatf("channel %0d arrived with nothing pending",
                                       o_channel_index));
            end else begin
                want = pending_q.pop_front();
                check_field("index", int'(want.idx), 32'(o_channel_index),
                            32'(want.idx));
                check_field("raw value", int'(want.idx), 32'(o_raw_value),
                            32'(want.raw));
                check_field("calibrated value", int'(want.idx), 32'(o_calibrated_value),
                            32'(want.cal));
                check_field("last flag", int'(want.idx), 32'(o_last_channel),
                            32'(want.last));
            end
        end
        i_res_stall <= ($urandom_range(99) < receiver_gap_pct);
    end

    // Stop a hung run when no request moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_rx_valid && !o_rx_stall) || (o_res_valid && !i_res_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int row;
        int ch;
        int phase;
        int seq_count;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frame right after reset, with the default calibration.
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            send_byte(directed_rows[row].data);
            if (shift_in(directed_rows[row].data)) begin
                if (directed_rows[row].typed) begin
                    for (ch = 0; ch < sfcd_pkg::NUM_CHANNELS; ch++) begin
                        push_channel(ch, directed_rows[row].raw, directed_rows[row].cal);
                    end
                end else begin
                    push_predicted();
                end
            end
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            // Calibration changes only while the block is drained.
            if (phase != 0) begin
                settle();
                case (phase)
                    1: begin
                        write_reg(sfcd_pkg::CFG_SCALE_IDX,
                                  sfcd_pkg::CFG_DATA_W'(16'hFFFF));
                        write_reg(sfcd_pkg::CFG_BIAS_IDX,
                                  {sfcd_pkg::CFG_DATA_W{1'b1}});
                    end
                    2: begin
                        write_reg(sfcd_pkg::CFG_SCALE_IDX, '0);
                        write_reg(sfcd_pkg::CFG_BIAS_IDX, '0);
                    end
                    3: begin
                        write_reg(sfcd_pkg::CFG_SCALE_IDX,
                                  sfcd_pkg::CFG_DATA_W'($urandom_range(65535)));
                        write_reg(sfcd_pkg::CFG_BIAS_IDX,
                                  sfcd_pkg::CFG_DATA_W'($urandom()));
                        write_reg(CFG_SPARE_A_IDX, sfcd_pkg::CFG_DATA_W'($urandom()));
                        write_reg(CFG_SPARE_B_IDX, sfcd_pkg::CFG_DATA_W'($urandom()));
                    end
                    default: begin
                        // Upper data bits set on the gain write must be dropped.
                        write_reg(sfcd_pkg::CFG_SCALE_IDX,
                                  {10'($urandom_range(1023, 1)), 16'($urandom())});
                        write_reg(sfcd_pkg::CFG_BIAS_IDX,
                                  sfcd_pkg::CFG_DATA_W'($urandom()));
                    end
                endcase
                i_cfg_we <= 1'b0;
            end

            if (phase < 2) begin
                sender_gap_pct   = 18;
                receiver_gap_pct = 64;
            end else if (phase < 4) begin
                sender_gap_pct   = 64;
                receiver_gap_pct = 18;
            end else begin
                sender_gap_pct   = 0;
                receiver_gap_pct = 0;
            end

            phase_bytes = 0;
            seq_count   = 0;
            while (phase_bytes < ((phase == 0) ? 20 : 30)) begin
                // After the first sequence the sender holds off until all channels are out.
                if (seq_count == 1) begin
                    settle();
                end
                send_sequence();
                seq_count++;
            end
        end

        settle();
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
design/sfcd_pkg.sv
design/sfcd_front.sv
design/sfcd_queue.sv
design/sfcd_back.sv
design/sbus_frame_channel_decoder.sv
sim/tb_sbus_frame_channel_decoder.sv
